@@ rtl/assert_macros.svh @@
// Assertion macros shared by the speed ratio regulator RTL.
// Files that check their logic include this header; the macros need clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define SRDR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define SRDR_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ rtl/srdr_pkg.sv @@
`timescale 1ns / 1ps
// Package of the speed ratio deadband regulator: types, codes, widths and reset values.
// No dependencies; every other RTL file but srdr_in_if imports it.
package srdr_pkg;

  localparam int GAIN_W     = 24;
  localparam int TOL_W      = 16;
  localparam int WIN_W      = 16;
  localparam int SPEED_W    = 32;
  localparam int FRAC_W     = 16;
  localparam int FACT_W     = FRAC_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int NUM_FEEDS  = 2;
  localparam int FEED_A     = 0;
  localparam int FEED_P     = 1;

  // reciprocal multiplier is split into two partial products
  localparam int RLO_W = 17;
  localparam int RHI_W = 16;

  localparam logic [FACT_W-1:0]  ONE_Q16     = 17'h1_0000;
  localparam logic [SPEED_W-1:0] ONE_SPEED   = 32'h0001_0000;

  localparam logic [GAIN_W-1:0] GAIN_A_RST    = 24'd107556;
  localparam logic [GAIN_W-1:0] GAIN_P_RST    = 24'd200274;
  localparam logic [TOL_W-1:0]  TOL_RST       = 16'd328;
  localparam logic [WIN_W-1:0]  ACCEL_WIN_RST = 16'd40;
  localparam logic [WIN_W-1:0]  ALARM_WIN_RST = 16'd600;

  localparam logic [1:0] PHASE_WAIT  = 2'd0;
  localparam logic [1:0] PHASE_ACCEL = 2'd1;
  localparam logic [1:0] PHASE_PROC  = 2'd2;

  typedef enum logic [2:0] {
    ST_WAIT  = 3'b001,
    ST_ACCEL = 3'b010,
    ST_PROC  = 3'b100
  } phase_e;

  typedef enum logic [1:0] {
    COR_OK    = 2'd0,
    COR_LEFT  = 2'd1,
    COR_RIGHT = 2'd2
  } corr_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_A    = 3'd0,
    CFG_GAIN_P    = 3'd1,
    CFG_TOLERANCE = 3'd2,
    CFG_ACCEL_WIN = 3'd3,
    CFG_ALARM_WIN = 3'd4
  } cfg_idx_e;

  // load enables of the five front stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

  function automatic logic [1:0] phase_code(phase_e st);
    unique case (st)
      ST_WAIT:  return PHASE_WAIT;
      ST_ACCEL: return PHASE_ACCEL;
      ST_PROC:  return PHASE_PROC;
      default:  return PHASE_WAIT;
    endcase
  endfunction

endpackage

@@ rtl/srdr_in_if.sv @@
`timescale 1ns / 1ps
// Input channel of the speed ratio regulator: valid/ready plus one item's fields.
// Depends on nothing; the count width is a parameter of the interface.
interface srdr_in_if #(
  parameter int COUNT_BITS = 20
) ();
  logic                  valid;
  logic                  ready;
  logic                  run_active;
  logic                  window_done;
  logic [COUNT_BITS-1:0] count_a;
  logic [COUNT_BITS-1:0] count_p;

  modport source (output valid, run_active, window_done, count_a, count_p, input ready);
  modport sink   (input valid, run_active, window_done, count_a, count_p, output ready);
endinterface

@@ rtl/srdr_out_if.sv @@
`timescale 1ns / 1ps
// Result channel of the speed ratio regulator: valid/ready plus one result item.
// Depends on srdr_pkg for the speed width.
interface srdr_out_if import srdr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         phase;
  logic [1:0]         correction;
  logic               alarm;
  logic [SPEED_W-1:0] speed_a;
  logic [SPEED_W-1:0] speed_p;

  modport source (output valid, phase, correction, alarm, speed_a, speed_p, input ready);
  modport sink   (input valid, phase, correction, alarm, speed_a, speed_p, output ready);
endinterface

@@ rtl/srdr_scale.sv @@
`timescale 1ns / 1ps
// Sample front end of one feed: count times gain, saturate to Q.16, split by the ring depth.
// Depends on srdr_pkg; stage enables come from the top level's valid chain.
module srdr_scale import srdr_pkg::*; #(
  parameter int AVG_DEPTH  = 35,
  parameter int COUNT_BITS = 20,
  parameter int QS_W       = 27,
  parameter int RS_W       = 6
) (
  input  logic                  clk_i,
  input  stage_en_t             en_i,
  input  logic [COUNT_BITS-1:0] count_i,
  input  logic [GAIN_W-1:0]     gain_i,
  output logic [QS_W-1:0]       qs_o,
  output logic [RS_W-1:0]       rs_o
);

  localparam int PROD_W = COUNT_BITS + GAIN_W;
  localparam int DIV_L  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 0;
  localparam int DIV_S  = SPEED_W + DIV_L;
  localparam logic [63:0] RECIP =
    ((64'd1 << DIV_S) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH);
  localparam logic [RLO_W-1:0] RECIP_LO = RECIP[RLO_W-1:0];
  localparam logic [RHI_W-1:0] RECIP_HI = RECIP[RLO_W+RHI_W-1:RLO_W];
  localparam int PLO_W  = SPEED_W + RLO_W;
  localparam int PHI_W  = SPEED_W + RHI_W;
  localparam int FULL_W = SPEED_W + RLO_W + RHI_W + 1;
  localparam int W1     = SPEED_W + 1;

  logic [COUNT_BITS-1:0] cnt_q;
  logic [PROD_W-1:0]     prod_q;
  logic [63:0]           prod_ext;
  logic [SPEED_W-1:0]    spd_d;
  logic [SPEED_W-1:0]    spd3_q;
  logic [PLO_W-1:0]      plo_q;
  logic [PHI_W-1:0]      phi_q;
  logic [FULL_W-1:0]     full_sum;
  logic [QS_W-1:0]       qs4_d;
  logic [QS_W-1:0]       qs4_q;
  logic [SPEED_W-1:0]    spd4_q;
  logic [W1-1:0]         qd;
  logic [W1-1:0]         rem;
  logic [QS_W-1:0]       qs5_d;
  logic [RS_W-1:0]       rs5_d;
  logic [QS_W-1:0]       qs5_q;
  logic [RS_W-1:0]       rs5_q;

  // (count * gain) >> 4, saturated to 32 bits
  always_comb begin
    prod_ext = 64'(prod_q);
    spd_d    = (|prod_ext[63:SPEED_W+4]) ? '1 : prod_ext[SPEED_W+3:4];
  end

  always_comb begin
    full_sum = (FULL_W'(phi_q) << RLO_W) + FULL_W'(plo_q);
    qs4_d    = QS_W'(full_sum >> DIV_S);
  end

  always_comb begin
    qd  = W1'(qs4_q) * W1'(AVG_DEPTH);
    rem = W1'(spd4_q) - qd;
    if (rem >= W1'(AVG_DEPTH)) begin
      qs5_d = qs4_q + QS_W'(1);
      rs5_d = RS_W'(rem - W1'(AVG_DEPTH));
    end else begin
      qs5_d = qs4_q;
      rs5_d = RS_W'(rem);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      cnt_q <= count_i;
    end
    if (en_i.s2) begin
      prod_q <= PROD_W'(cnt_q) * PROD_W'(gain_i);
    end
    if (en_i.s3) begin
      spd3_q <= spd_d;
      plo_q  <= PLO_W'(spd_d) * PLO_W'(RECIP_LO);
      phi_q  <= PHI_W'(spd_d) * PHI_W'(RECIP_HI);
    end
    if (en_i.s4) begin
      spd4_q <= spd3_q;
      qs4_q  <= qs4_d;
    end
    if (en_i.s5) begin
      qs5_q <= qs5_d;
      rs5_q <= rs5_d;
    end
  end

  assign qs_o = qs5_q;
  assign rs_o = rs5_q;

endmodule

@@ rtl/speed_ratio_deadband_regulator.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Speed ratio deadband regulator, top level.
// Depends on srdr_pkg, srdr_in_if, srdr_out_if and srdr_scale.
//
// Usage:
//   in_if carries one item per handshake: run input, window-closed flag and the
//   pulse counts of feeds A and P. out_if returns exactly one result item per
//   input item: phase, correction, latched alarm and the averaged A and P speeds.
//   The cfg_* port writes gain_a, gain_p, tolerance, accel_windows and
//   alarm_windows (index 0 to 4); write only while the block holds no item.
//   An accepted item passes the five front stages, which compute the scaled
//   sample and its quotient and remainder by the ring depth, and then the
//   output register. Throughput: one item per cycle while the receiver takes
//   results. The ring state and the ratio test update together, with one read
//   and at most one write of the averaging memory per item.
//   A stalled receiver holds the output register; the front stages keep taking
//   items until they are all full, and only then is in_if.ready dropped.
//   Reset restores the register defaults, phase waiting, correction ok and zero
//   averages at once; no clearing pass is needed.
module speed_ratio_deadband_regulator import srdr_pkg::*; #(
  parameter int AVG_DEPTH  = 35,
  parameter int COUNT_BITS = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  srdr_in_if.sink               in_if,
  srdr_out_if.source            out_if
);

  localparam int QS_W   = $clog2((64'hFFFF_FFFF / 64'(AVG_DEPTH)) + 64'd1);
  localparam int RS_W   = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int AW     = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int FILL_W = $clog2(AVG_DEPTH + 1);
  localparam int ENT_W  = QS_W + RS_W;
  localparam int RSUM_W = RS_W + 2;
  localparam int CMP_W  = SPEED_W + FACT_W;

  // configuration
  logic [GAIN_W-1:0] gain_a_q;
  logic [GAIN_W-1:0] gain_p_q;
  logic [TOL_W-1:0]  tol_q;
  logic [WIN_W-1:0]  accel_win_q;
  logic [WIN_W-1:0]  alarm_win_q;

  // front pipeline
  stage_en_t  en;
  logic       out_en;
  logic [4:0] vld_q;
  logic       out_vld_q;
  logic [4:0] run_q;
  logic [4:0] win_q;
  logic       step;
  logic [QS_W-1:0] qs5 [NUM_FEEDS];
  logic [RS_W-1:0] rs5 [NUM_FEEDS];

  // regulator state
  phase_e             state_q, state_d;
  corr_e              corr_q, corr_d;
  logic [WIN_W-1:0]   accel_left_q, accel_left_d;
  logic [WIN_W-1:0]   alarm_left_q, alarm_left_d;
  logic               alarm_q, alarm_d;
  logic [AW-1:0]      pos_q, pos_d, pos_inc;
  logic [FILL_W-1:0]  fill_q, fill_d, fill_inc;
  logic [SPEED_W-1:0] q_q [NUM_FEEDS];
  logic [SPEED_W-1:0] q_d [NUM_FEEDS];
  logic [SPEED_W-1:0] q_upd [NUM_FEEDS];
  logic [RS_W-1:0]    r_q [NUM_FEEDS];
  logic [RS_W-1:0]    r_d [NUM_FEEDS];
  logic [RS_W-1:0]    r_upd [NUM_FEEDS];

  // averaging ring: quotient and remainder of each sample, both feeds per row
  logic [NUM_FEEDS*ENT_W-1:0] mem [AVG_DEPTH];
  logic [NUM_FEEDS*ENT_W-1:0] rd_q;
  logic [NUM_FEEDS*ENT_W-1:0] ent_new;
  logic                       mem_we;
  logic                       old_ok;

  // ratio test
  logic [SPEED_W-1:0] a_eff, p_eff;
  logic [FACT_W-1:0]  band_hi, band_lo;
  logic [CMP_W-1:0]   lhs, rhs_l, rhs_r;
  logic               hit_left, hit_right;

  // result register
  logic [1:0]         out_phase_q;
  logic [1:0]         out_corr_q;
  logic               out_alarm_q;
  logic [SPEED_W-1:0] out_speed_a_q;
  logic [SPEED_W-1:0] out_speed_p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_a_q    <= GAIN_A_RST;
      gain_p_q    <= GAIN_P_RST;
      tol_q       <= TOL_RST;
      accel_win_q <= ACCEL_WIN_RST;
      alarm_win_q <= ALARM_WIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GAIN_A:    gain_a_q    <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_P:    gain_p_q    <= cfg_data_i[GAIN_W-1:0];
        CFG_TOLERANCE: tol_q       <= cfg_data_i[TOL_W-1:0];
        CFG_ACCEL_WIN: accel_win_q <= cfg_data_i[WIN_W-1:0];
        CFG_ALARM_WIN: alarm_win_q <= cfg_data_i[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or its item moves on
  always_comb begin
    out_en = !out_vld_q || out_if.ready;
    en.s5  = !vld_q[4] || out_en;
    en.s4  = !vld_q[3] || en.s5;
    en.s3  = !vld_q[2] || en.s4;
    en.s2  = !vld_q[1] || en.s3;
    en.s1  = !vld_q[0] || en.s2;
  end

  assign in_if.ready = en.s1;
  assign step        = vld_q[4] && out_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (en.s1) vld_q[0] <= in_if.valid;
      if (en.s2) vld_q[1] <= vld_q[0];
      if (en.s3) vld_q[2] <= vld_q[1];
      if (en.s4) vld_q[3] <= vld_q[2];
      if (en.s5) vld_q[4] <= vld_q[3];
      if (out_en) out_vld_q <= vld_q[4];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en.s1) begin
      run_q[0] <= in_if.run_active;
      win_q[0] <= in_if.window_done;
    end
    if (en.s2) begin
      run_q[1] <= run_q[0];
      win_q[1] <= win_q[0];
    end
    if (en.s3) begin
      run_q[2] <= run_q[1];
      win_q[2] <= win_q[1];
    end
    if (en.s4) begin
      run_q[3] <= run_q[2];
      win_q[3] <= win_q[2];
    end
    if (en.s5) begin
      run_q[4] <= run_q[3];
      win_q[4] <= win_q[3];
    end
  end

  srdr_scale #(
    .AVG_DEPTH  (AVG_DEPTH),
    .COUNT_BITS (COUNT_BITS),
    .QS_W       (QS_W),
    .RS_W       (RS_W)
  ) u_scale_a (
    .clk_i   (clk_i),
    .en_i    (en),
    .count_i (in_if.count_a),
    .gain_i  (gain_a_q),
    .qs_o    (qs5[FEED_A]),
    .rs_o    (rs5[FEED_A])
  );

  srdr_scale #(
    .AVG_DEPTH  (AVG_DEPTH),
    .COUNT_BITS (COUNT_BITS),
    .QS_W       (QS_W),
    .RS_W       (RS_W)
  ) u_scale_p (
    .clk_i   (clk_i),
    .en_i    (en),
    .count_i (in_if.count_p),
    .gain_i  (gain_p_q),
    .qs_o    (qs5[FEED_P]),
    .rs_o    (rs5[FEED_P])
  );

  // zero average counts as 1.0
  always_comb begin
    a_eff     = (q_q[FEED_A] == '0) ? ONE_SPEED : q_q[FEED_A];
    p_eff     = (q_q[FEED_P] == '0) ? ONE_SPEED : q_q[FEED_P];
    band_hi   = ONE_Q16 + FACT_W'(tol_q);
    band_lo   = ONE_Q16 - FACT_W'(tol_q);
    lhs       = CMP_W'({a_eff, {FRAC_W{1'b0}}});
    rhs_l     = CMP_W'(p_eff) * CMP_W'(band_hi);
    rhs_r     = CMP_W'(p_eff) * CMP_W'(band_lo);
    hit_left  = lhs >= rhs_l;
    hit_right = lhs <= rhs_r;
  end

  // running sums kept as quotient and remainder by the ring depth
  always_comb begin
    logic [ENT_W-1:0]   ent_old;
    logic [SPEED_W-1:0] qo;
    logic [RS_W-1:0]    ro;
    logic [SPEED_W-1:0] qbase;
    logic [RSUM_W-1:0]  rsum;
    old_ok  = FILL_W'(pos_q) < fill_q;
    ent_new = '0;
    for (int i = 0; i < NUM_FEEDS; i++) begin
      ent_old = rd_q[i*ENT_W +: ENT_W];
      qo      = old_ok ? SPEED_W'(ent_old[ENT_W-1:RS_W]) : '0;
      ro      = old_ok ? ent_old[RS_W-1:0] : '0;
      qbase   = q_q[i] + SPEED_W'(qs5[i]) - qo;
      rsum    = RSUM_W'(r_q[i]) + RSUM_W'(rs5[i]) + RSUM_W'(AVG_DEPTH) - RSUM_W'(ro);
      if (rsum >= RSUM_W'(2 * AVG_DEPTH)) begin
        r_upd[i] = RS_W'(rsum - RSUM_W'(2 * AVG_DEPTH));
        q_upd[i] = qbase + SPEED_W'(1);
      end else if (rsum >= RSUM_W'(AVG_DEPTH)) begin
        r_upd[i] = RS_W'(rsum - RSUM_W'(AVG_DEPTH));
        q_upd[i] = qbase;
      end else begin
        r_upd[i] = RS_W'(rsum);
        q_upd[i] = qbase - SPEED_W'(1);
      end
      ent_new[i*ENT_W +: ENT_W] = {qs5[i], rs5[i]};
    end
    pos_inc  = (pos_q == AW'(AVG_DEPTH - 1)) ? '0 : pos_q + AW'(1);
    fill_inc = (fill_q == FILL_W'(AVG_DEPTH)) ? fill_q : fill_q + FILL_W'(1);
  end

  always_comb begin
    state_d      = state_q;
    corr_d       = corr_q;
    accel_left_d = accel_left_q;
    alarm_left_d = alarm_left_q;
    alarm_d      = alarm_q;
    pos_d        = pos_q;
    fill_d       = fill_q;
    q_d          = q_q;
    r_d          = r_q;
    mem_we       = 1'b0;
    if (step) begin
      if (run_q[4]) begin
        if (state_q == ST_WAIT) begin
          state_d      = ST_ACCEL;
          accel_left_d = accel_win_q;
          alarm_left_d = alarm_win_q;
          alarm_d      = 1'b0;
        end else if (state_q == ST_ACCEL && accel_left_q == '0) begin
          state_d = ST_PROC;
        end
      end else if (state_q != ST_WAIT) begin
        state_d = ST_WAIT;
        pos_d   = '0;
        fill_d  = '0;
        for (int i = 0; i < NUM_FEEDS; i++) begin
          q_d[i] = '0;
          r_d[i] = '0;
        end
      end

      if (state_d == ST_PROC) begin
        priority if (hit_left) begin
          corr_d = COR_LEFT;
        end else if (hit_right) begin
          corr_d = COR_RIGHT;
        end else if (corr_q != COR_OK) begin
          if (alarm_left_d < alarm_win_q) alarm_left_d = alarm_win_q;
          corr_d = COR_OK;
        end else begin
          corr_d = COR_OK;
        end
      end

      if (win_q[4] && (state_d == ST_PROC || state_d == ST_ACCEL)) begin
        mem_we = 1'b1;
        q_d    = q_upd;
        r_d    = r_upd;
        pos_d  = pos_inc;
        fill_d = fill_inc;
        if (corr_d != COR_OK && alarm_left_d != '0 && !alarm_d) begin
          alarm_left_d = alarm_left_d - WIN_W'(1);
        end
        if (alarm_left_d == '0 && !alarm_d) alarm_d = 1'b1;
      end

      if (win_q[4] && accel_left_d != '0) accel_left_d = accel_left_d - WIN_W'(1);
    end
  end

  // read ahead the entry that the next window will replace
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[pos_q] <= ent_new;
    if (mem_we && pos_d == pos_q) begin
      rd_q <= ent_new;
    end else begin
      rd_q <= mem[pos_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_WAIT;
      corr_q       <= COR_OK;
      accel_left_q <= '0;
      alarm_left_q <= ALARM_WIN_RST;
      alarm_q      <= 1'b0;
      pos_q        <= '0;
      fill_q       <= '0;
      for (int i = 0; i < NUM_FEEDS; i++) begin
        q_q[i] <= '0;
        r_q[i] <= '0;
      end
    end else begin
      state_q      <= state_d;
      corr_q       <= corr_d;
      accel_left_q <= accel_left_d;
      alarm_left_q <= alarm_left_d;
      alarm_q      <= alarm_d;
      pos_q        <= pos_d;
      fill_q       <= fill_d;
      q_q          <= q_d;
      r_q          <= r_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      out_phase_q   <= phase_code(state_d);
      out_corr_q    <= corr_d;
      out_alarm_q   <= alarm_d;
      out_speed_a_q <= q_d[FEED_A];
      out_speed_p_q <= q_d[FEED_P];
    end
  end

  assign out_if.valid      = out_vld_q;
  assign out_if.phase      = out_phase_q;
  assign out_if.correction = out_corr_q;
  assign out_if.alarm      = out_alarm_q;
  assign out_if.speed_a    = out_speed_a_q;
  assign out_if.speed_p    = out_speed_p_q;

  `SRDR_ASSERT_NEVER(a_fill_bound, fill_q > FILL_W'(AVG_DEPTH), "ring fill count beyond depth")
  `SRDR_ASSERT(a_rem_a_bound, RSUM_W'(r_q[FEED_A]) < RSUM_W'(AVG_DEPTH), "feed A remainder too big")
  `SRDR_ASSERT(a_rem_p_bound, RSUM_W'(r_q[FEED_P]) < RSUM_W'(AVG_DEPTH), "feed P remainder too big")
  `SRDR_ASSERT(a_alarm_rise, $rose(alarm_q) |-> alarm_left_q == '0, "alarm latched with windows left")
  `SRDR_ASSERT(a_proc_entry, (state_q == ST_PROC && $past(state_q) != ST_PROC) |-> $past(state_q) == ST_ACCEL, "process entered not from acceleration")
  `SRDR_ASSERT(a_state_hold, !$past(step) |-> $stable(state_q), "phase moved without an item")

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench of speed_ratio_deadband_regulator: drives run/window items with random gaps and stalls,
// predicts every result item from its own copy of the regulator state and checks it field by field.
// Depends on srdr_pkg, srdr_in_if, srdr_out_if and the regulator RTL.
module tb_top;
  import srdr_pkg::*;

  localparam int DEPTH       = 35;
  localparam int CNT_W       = 20;
  localparam int LATENCY     = 5;
  localparam int STALL_LIMIT = 2000;
  localparam int PRINT_LIMIT = 50;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum int {MODE_BALANCED, MODE_RANDOM, MODE_ZERO, MODE_FULL} count_mode_e;

  typedef struct packed {
    logic             run;
    logic             win;
    logic [CNT_W-1:0] cnt_a;
    logic [CNT_W-1:0] cnt_p;
  } window_item_t;

  typedef struct packed {
    logic [1:0]         phase;
    corr_e              corr;
    logic               alarm;
    logic [SPEED_W-1:0] spd_a;
    logic [SPEED_W-1:0] spd_p;
  } status_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  srdr_in_if #(.COUNT_BITS(CNT_W)) in_ch ();
  srdr_out_if out_ch ();

  speed_ratio_deadband_regulator #(
    .AVG_DEPTH (DEPTH),
    .COUNT_BITS(CNT_W)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_if     (in_ch.sink),
    .out_if    (out_ch.source)
  );

  always #1 clk_i = ~clk_i;

  // register copies
  logic [GAIN_W-1:0] gain_a_cfg, gain_p_cfg;
  logic [TOL_W-1:0]  tol_cfg;
  logic [WIN_W-1:0]  accel_cfg, alarm_cfg;

  // regulator state copy
  logic [1:0]         phase_q;
  corr_e              corr_q;
  logic [WIN_W-1:0]   accel_left, alarm_left;
  logic               alarm_q;
  logic [SPEED_W-1:0] hist_a [DEPTH];
  logic [SPEED_W-1:0] hist_p [DEPTH];
  logic [37:0]        total_a, total_p;
  int                 slot;

  window_item_t items_q [$];
  status_t      status_q [$];
  window_item_t held_item;
  int           outstanding = 0;
  int           mismatches = 0;
  int           quiet_cycles = 0;
  bit           steady = 1'b0;

  function automatic void clear_history();
    for (int i = 0; i < DEPTH; i++) begin
      hist_a[i] = '0;
      hist_p[i] = '0;
    end
    total_a = '0;
    total_p = '0;
    slot = 0;
  endfunction

  function automatic logic [SPEED_W-1:0] to_speed(logic [CNT_W-1:0] cnt,
                                                  logic [GAIN_W-1:0] gain);
    logic [CNT_W+GAIN_W-1:0] prod;
    prod = cnt * gain;
    prod = prod >> 4;
    return (prod > 44'hFFFF_FFFF) ? '1 : prod[SPEED_W-1:0];
  endfunction

  task automatic advance_regulator(input window_item_t it, output status_t res);
    logic [63:0]        avg_a, avg_p, lhs;
    logic [SPEED_W-1:0] new_a, new_p;
    if (it.run) begin
      if (phase_q == PHASE_WAIT) begin
        accel_left = accel_cfg;
        phase_q = PHASE_ACCEL;
        alarm_left = alarm_cfg;
        alarm_q = 1'b0;
      end else if (phase_q == PHASE_ACCEL && accel_left == 0) begin
        phase_q = PHASE_PROC;
      end
    end else if (phase_q != PHASE_WAIT) begin
      clear_history();
      phase_q = PHASE_WAIT;
    end
    // ratio test runs on the averages before this item's window
    if (phase_q == PHASE_PROC) begin
      avg_a = total_a / DEPTH;
      avg_p = total_p / DEPTH;
      if (avg_a == 0) avg_a = ONE_SPEED;
      if (avg_p == 0) avg_p = ONE_SPEED;
      lhs = avg_a << FRAC_W;
      if (lhs >= avg_p * (64'(ONE_SPEED) + tol_cfg)) begin
        corr_q = COR_LEFT;
      end else if (lhs <= avg_p * (64'(ONE_SPEED) - tol_cfg)) begin
        corr_q = COR_RIGHT;
      end else if (corr_q != COR_OK) begin
        if (alarm_left < alarm_cfg) alarm_left = alarm_cfg;
        corr_q = COR_OK;
      end
    end
    if (it.win) begin
      if (phase_q != PHASE_WAIT) begin
        new_a = to_speed(it.cnt_a, gain_a_cfg);
        new_p = to_speed(it.cnt_p, gain_p_cfg);
        total_a = total_a - hist_a[slot] + new_a;
        total_p = total_p - hist_p[slot] + new_p;
        hist_a[slot] = new_a;
        hist_p[slot] = new_p;
        slot = (slot + 1) % DEPTH;
        if (corr_q != COR_OK && alarm_left != 0 && !alarm_q) alarm_left--;
        if (alarm_left == 0 && !alarm_q) alarm_q = 1'b1;
      end
      if (accel_left != 0) accel_left--;
    end
    res.phase = phase_q;
    res.corr  = corr_q;
    res.alarm = alarm_q;
    res.spd_a = SPEED_W'(total_a / DEPTH);
    res.spd_p = SPEED_W'(total_p / DEPTH);
  endtask

  task automatic report(input string what, input logic [SPEED_W-1:0] got,
                        input logic [SPEED_W-1:0] want);
    if (mismatches < PRINT_LIMIT)
      $display("%0t: %s mismatch: got %0h expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // driver
  always @(posedge clk_i) begin
    window_item_t nxt;
    status_t      res;
    bit           send;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        advance_regulator(held_item, res);
        status_q.push_back(res);
      end
      if (!in_ch.valid || in_ch.ready) begin
        send = items_q.size() != 0 && (steady || $urandom_range(0, 99) >= 10);
        if (send) begin
          nxt = items_q.pop_front();
          held_item = nxt;
          in_ch.run_active  <= nxt.run;
          in_ch.window_done <= nxt.win;
          in_ch.count_a     <= nxt.cnt_a;
          in_ch.count_p     <= nxt.cnt_p;
        end
        in_ch.valid <= send;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    status_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (status_q.size() == 0) begin
          report("unexpected result item", out_ch.speed_a, '0);
        end else begin
          want = status_q.pop_front();
          outstanding--;
          if (out_ch.phase !== want.phase) report("phase", out_ch.phase, want.phase);
          if (out_ch.correction !== want.corr) report("correction", out_ch.correction, want.corr);
          if (out_ch.alarm !== want.alarm) report("alarm", out_ch.alarm, want.alarm);
          if (out_ch.speed_a !== want.spd_a) report("speed_a", out_ch.speed_a, want.spd_a);
          if (out_ch.speed_p !== want.spd_p) report("speed_p", out_ch.speed_p, want.spd_p);
        end
      end
      out_ch.ready <= steady || $urandom_range(0, 99) >= 10;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL speed_ratio_deadband_regulator");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void queue_item(window_item_t it);
    items_q.push_back(it);
    outstanding++;
  endfunction

  function automatic window_item_t mk_item(logic run, logic win, logic [CNT_W-1:0] ca,
                                           logic [CNT_W-1:0] cp);
    window_item_t it;
    it.run   = run;
    it.win   = win;
    it.cnt_a = ca;
    it.cnt_p = cp;
    return it;
  endfunction

  function automatic count_mode_e pick_mode();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return MODE_BALANCED;
    if (r < 8) return MODE_RANDOM;
    if (r == 8) return MODE_ZERO;
    return MODE_FULL;
  endfunction

  // running item; balanced counts keep the A/P speed ratio near the deadband
  function automatic window_item_t run_window(count_mode_e mode);
    window_item_t it;
    longint       skew, num;
    it.run = 1'b1;
    it.win = $urandom_range(0, 99) < 85;
    case (mode)
      MODE_BALANCED: begin
        it.cnt_a = $urandom_range(256, CNT_MAX);
        skew = longint'($urandom_range(0, 2 * tol_cfg + 20)) - longint'(tol_cfg) - 10;
        if (skew < -65535) skew = -65535;
        if (gain_p_cfg == 0) begin
          it.cnt_p = $urandom;
        end else begin
          num = (longint'(it.cnt_a) * gain_a_cfg * (65536 + skew)) /
                (longint'(gain_p_cfg) * 65536);
          it.cnt_p = (num > CNT_MAX) ? CNT_MAX : num[CNT_W-1:0];
        end
      end
      MODE_RANDOM: begin
        it.cnt_a = $urandom;
        it.cnt_p = $urandom;
      end
      MODE_ZERO: begin
        it.cnt_a = '0;
        it.cnt_p = '0;
      end
      default: begin
        it.cnt_a = CNT_MAX;
        it.cnt_p = CNT_MAX;
      end
    endcase
    return it;
  endfunction

  task automatic gen_phase(input int amount);
    int           made, len;
    count_mode_e  mode;
    window_item_t it;
    made = 0;
    while (made < amount) begin
      if ($urandom_range(0, 99) < 15) begin
        it.run   = $urandom;
        it.win   = $urandom;
        it.cnt_a = $urandom;
        it.cnt_p = $urandom;
        queue_item(it);
        made++;
      end else begin
        repeat ($urandom_range(0, 2)) begin
          it = run_window(pick_mode());
          it.run = 1'b0;
          queue_item(it);
          made++;
        end
        len = ((accel_cfg > 60) ? 60 : accel_cfg) + $urandom_range(1, 70);
        mode = pick_mode();
        repeat (len) begin
          if ($urandom_range(0, 9) == 0) mode = pick_mode();
          queue_item(run_window(mode));
          made++;
        end
        it = run_window(mode);
        it.run = 1'b0;
        queue_item(it);
        made++;
      end
    end
  endtask

  task automatic set_config(input logic [GAIN_W-1:0] ga, gp, input logic [TOL_W-1:0] tol,
                            input logic [WIN_W-1:0] acc, alm);
    cfg_idx_e              idx;
    logic [CFG_DATA_W-1:0] val;
    for (int i = 0; i <= CFG_ALARM_WIN; i++) begin
      idx = cfg_idx_e'(i);
      case (idx)
        CFG_GAIN_A:    val = ga;
        CFG_GAIN_P:    val = gp;
        CFG_TOLERANCE: val = tol;
        CFG_ACCEL_WIN: val = acc;
        CFG_ALARM_WIN: val = alm;
        default:       val = '0;
      endcase
      @(posedge clk_i);
      cfg_we   <= 1'b1;
      cfg_idx  <= idx;
      cfg_data <= val;
    end
    @(posedge clk_i);
    cfg_we <= 1'b0;
    gain_a_cfg = ga;
    gain_p_cfg = gp;
    tol_cfg    = tol;
    accel_cfg  = acc;
    alarm_cfg  = alm;
  endtask

  // wait until every queued item has had its result checked
  task automatic settle();
    while (outstanding != 0) @(posedge clk_i);
    repeat (LATENCY + 3) @(posedge clk_i);
  endtask

  initial begin
    int                amount;
    logic [GAIN_W-1:0] ga;
    longint            gp_wide;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.run_active = 1'b0;
    in_ch.window_done = 1'b0;
    in_ch.count_a = '0;
    in_ch.count_p = '0;
    out_ch.ready = 1'b0;
    gain_a_cfg = GAIN_A_RST;
    gain_p_cfg = GAIN_P_RST;
    tol_cfg    = TOL_RST;
    accel_cfg  = ACCEL_WIN_RST;
    alarm_cfg  = ALARM_WIN_RST;
    phase_q    = PHASE_WAIT;
    corr_q     = COR_OK;
    accel_left = '0;
    alarm_left = ALARM_WIN_RST;
    alarm_q    = 1'b0;
    clear_history();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: saturated A speed, one accel window, short alarm countdown
    set_config(24'hFF_FFFF, 24'd16, 16'd1000, 16'd1, 16'd2);
    queue_item(mk_item(1'b0, 1'b1, CNT_MAX, CNT_MAX));
    queue_item(mk_item(1'b0, 1'b0, '0, '0));
    queue_item(mk_item(1'b1, 1'b0, '0, '0));
    queue_item(mk_item(1'b1, 1'b1, CNT_MAX, CNT_MAX));
    queue_item(mk_item(1'b1, 1'b1, '0, '0));
    repeat (4) queue_item(mk_item(1'b1, 1'b1, '0, CNT_MAX));
    queue_item(mk_item(1'b1, 1'b0, '0, '0));
    queue_item(mk_item(1'b0, 1'b0, '0, '0));
    queue_item(mk_item(1'b0, 1'b1, CNT_MAX, CNT_MAX));
    repeat (3) queue_item(mk_item(1'b1, 1'b1, 20'd1, CNT_MAX));
    repeat (3) queue_item(mk_item(1'b1, 1'b1, '0, CNT_MAX));
    queue_item(mk_item(1'b0, 1'b1, '0, '0));
    queue_item(mk_item(1'b1, 1'b1, CNT_MAX, '0));
    queue_item(mk_item(1'b1, 1'b1, 20'hAAAAA, 20'h55555));
    queue_item(mk_item(1'b1, 1'b1, 20'h55555, 20'hAAAAA));
    queue_item(mk_item(1'b0, 1'b0, '0, '0));

    for (int k = 0; k < 8; k++) begin
      settle();
      steady <= (k == 0);
      case (k)
        0: begin
          set_config(GAIN_A_RST, GAIN_P_RST, TOL_RST, ACCEL_WIN_RST, ALARM_WIN_RST);
          amount = 200;
        end
        5: begin
          set_config('0, '0, '0, '0, '0);
          amount = 60;
        end
        6: begin
          set_config('1, '1, '1, '1, '1);
          amount = 60;
        end
        7: begin
          set_config('1, 24'd1, '0, '0, '0);
          amount = 60;
        end
        default: begin
          ga = $urandom_range(1, 24'hFF_FFFF) >> $urandom_range(0, 12);
          gp_wide = (longint'(ga) * $urandom_range(50, 200)) / 100;
          if (gp_wide > 24'hFF_FFFF) gp_wide = 24'hFF_FFFF;
          set_config(ga, gp_wide[GAIN_W-1:0], $urandom_range(0, 3000), $urandom_range(0, 8),
                     $urandom_range(0, 15));
          amount = 110;
        end
      endcase
      gen_phase(amount);
    end
    settle();

    if (mismatches == 0) begin
      $display("PASS speed_ratio_deadband_regulator");
    end else begin
      $display("FAIL speed_ratio_deadband_regulator");
    end
    $finish;
  end

endmodule

@@ speed_ratio_deadband_regulator.f @@
+incdir+rtl
rtl/srdr_pkg.sv
rtl/srdr_in_if.sv
rtl/srdr_out_if.sv
rtl/srdr_scale.sv
rtl/speed_ratio_deadband_regulator.sv
tb/tb_top.sv
